// ===== sv/arhe_pkg.sv =====
// ----------------------------------------------------------------------------
// arhe_pkg
// Shared widths, payload structs, register map and state types for the
// attack/release/hold envelope follower.
// ----------------------------------------------------------------------------
package arhe_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAG_BITS       = SAMPLE_BITS - 1;
   localparam int COEF_BITS      = 16;
   localparam int HOLD_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Unity gain in Q1.COEF_BITS, one bit wider than a coefficient.
   localparam logic [COEF_BITS:0]  COEF_ONE = {1'b1, {COEF_BITS{1'b0}}};
   // Largest representable magnitude.
   localparam logic [MAG_BITS-1:0] MAG_MAX  = {MAG_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ATTACK_COEF  = 2'd0,
      CSR_RELEASE_COEF = 2'd1,
      CSR_HOLD_LIMIT   = 2'd2,
      CSR_HOLD_ENABLE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          block_last;
   } req_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] envelope_level;
      logic                block_last_out;
   } rsp_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] attack_coef;
      logic [COEF_BITS-1:0] release_coef;
      logic [HOLD_BITS-1:0] hold_limit;
      logic                 hold_enable;
   } cfg_type;

   typedef struct packed {
      logic [MAG_BITS-1:0]  envelope_value;
      logic                 holding;
      logic [HOLD_BITS-1:0] hold_counter;
   } env_state_type;

endpackage

// ===== sv/arhe_update.sv =====
// ----------------------------------------------------------------------------
// arhe_update
// Next-state logic of the envelope follower: rectification, attack/release
// decision, one-pole smoothing step and hold counter.
// ----------------------------------------------------------------------------
module arhe_update (
   input  logic signed [arhe_pkg::SAMPLE_BITS-1:0] sample,
   input  arhe_pkg::cfg_type                       cfg,
   input  arhe_pkg::env_state_type                 state_cur,
   output arhe_pkg::env_state_type                 state_next
);

   localparam int PROD_BITS = arhe_pkg::MAG_BITS + arhe_pkg::COEF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int RAW_BITS  = SUM_BITS - arhe_pkg::COEF_BITS;

   logic [arhe_pkg::SAMPLE_BITS-1:0] negated;
   logic [arhe_pkg::MAG_BITS-1:0]    magnitude;
   logic                             attack;
   logic [arhe_pkg::COEF_BITS-1:0]   coef;
   logic [arhe_pkg::COEF_BITS:0]     coef_comp;
   logic [PROD_BITS-1:0]             prod_env;
   logic [PROD_BITS:0]               prod_in;
   logic [SUM_BITS-1:0]              sum;
   logic [RAW_BITS-1:0]              smooth_raw;
   logic [arhe_pkg::MAG_BITS-1:0]    smoothed;

   // Rectify. The most negative sample has no positive twin and saturates.
   assign negated = ~sample + 1'b1;

   always_comb begin
      if (!sample[arhe_pkg::SAMPLE_BITS-1]) begin
         magnitude = sample[arhe_pkg::MAG_BITS-1:0];
      end else if (negated[arhe_pkg::SAMPLE_BITS-1]) begin
         magnitude = arhe_pkg::MAG_MAX;
      end else begin
         magnitude = negated[arhe_pkg::MAG_BITS-1:0];
      end
   end

   assign attack = state_cur.envelope_value < magnitude;

   // One smoother serves both directions; only the coefficient changes.
   assign coef      = attack ? cfg.attack_coef : cfg.release_coef;
   assign coef_comp = arhe_pkg::COEF_ONE - {1'b0, coef};
   assign prod_env  = PROD_BITS'(state_cur.envelope_value) * PROD_BITS'(coef);
   assign prod_in   = (PROD_BITS + 1)'(magnitude) * (PROD_BITS + 1)'(coef_comp);
   assign sum       = SUM_BITS'(prod_env) + SUM_BITS'(prod_in);
   assign smooth_raw = sum[SUM_BITS-1:arhe_pkg::COEF_BITS];

   always_comb begin
      if (smooth_raw[RAW_BITS-1:arhe_pkg::MAG_BITS] != '0) begin
         smoothed = arhe_pkg::MAG_MAX;
      end else begin
         smoothed = smooth_raw[arhe_pkg::MAG_BITS-1:0];
      end
   end

   always_comb begin
      state_next = state_cur;
      priority if (attack) begin
         state_next.envelope_value = smoothed;
         if (cfg.hold_enable) begin
            state_next.holding      = 1'b1;
            state_next.hold_counter = '0;
         end
      end else if (cfg.hold_enable && state_cur.holding) begin
         if (state_cur.hold_counter == cfg.hold_limit) begin
            state_next.holding      = 1'b0;
            state_next.hold_counter = '0;
         end else begin
            state_next.hold_counter = state_cur.hold_counter + 1'b1;
         end
      end else begin
         state_next.envelope_value = smoothed;
      end
      // With hold off the hold machinery stays cleared.
      if (!cfg.hold_enable) begin
         state_next.holding      = 1'b0;
         state_next.hold_counter = '0;
      end
   end

endmodule

// ===== sv/attack_release_hold_envelope.sv =====
// ----------------------------------------------------------------------------
// attack_release_hold_envelope
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle while rsp_stall is low; the envelope recursion is a
// combinational update (two parallel multiplies and an add) between the input
// and result registers. Reset (synchronous) empties both stages, clears the
// envelope and hold state, and loads the register defaults.
// ----------------------------------------------------------------------------
// Peak envelope follower with attack, release and optional hold.
// ----------------------------------------------------------------------------
module attack_release_hold_envelope (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  arhe_pkg::req_type                     req_payload,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output arhe_pkg::rsp_type                     rsp_payload,

   input  logic                                  csr_write_enable,
   input  logic [arhe_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [arhe_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   // Configuration registers.
   arhe_pkg::cfg_type       cfg_ff, cfg_in;

   // Input register stage.
   logic                    in_valid_ff, in_valid_in;
   arhe_pkg::req_type       in_payload_ff, in_payload_in;

   // Envelope state carried from item to item.
   arhe_pkg::env_state_type state_ff, state_in, state_next;

   // Result register stage.
   logic                    rsp_valid_ff, rsp_valid_in;
   arhe_pkg::rsp_type       rsp_payload_ff, rsp_payload_in;

   logic                    req_accept;
   logic                    advance;

   // The item in the input register moves on whenever the result register
   // is empty or is being drained this cycle. The state update happens on
   // that same edge, so the next item always sees the updated state.
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   arhe_update u_update (
      .sample     (in_payload_ff.sample),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .state_next (state_next)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (arhe_pkg::csr_index_type'(csr_index))
            arhe_pkg::CSR_ATTACK_COEF: begin
               cfg_in.attack_coef = csr_data[arhe_pkg::COEF_BITS-1:0];
            end
            arhe_pkg::CSR_RELEASE_COEF: begin
               cfg_in.release_coef = csr_data[arhe_pkg::COEF_BITS-1:0];
            end
            arhe_pkg::CSR_HOLD_LIMIT: begin
               cfg_in.hold_limit = csr_data[arhe_pkg::HOLD_BITS-1:0];
            end
            arhe_pkg::CSR_HOLD_ENABLE: begin
               cfg_in.hold_enable = csr_data[0];
            end
         endcase
      end
   end

   always_comb begin
      // A new item may enter in the same cycle the previous one leaves.
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      in_payload_in = req_accept ? req_payload : in_payload_ff;

      state_in = advance ? state_next : state_ff;

      // The result register holds while stalled and empties once taken.
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_payload_in = rsp_payload_ff;
      if (advance) begin
         rsp_payload_in.envelope_level = state_next.envelope_value;
         rsp_payload_in.block_last_out = in_payload_ff.block_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coef  <= '0;
         cfg_ff.release_coef <= '0;
         cfg_ff.hold_limit   <= '0;
         cfg_ff.hold_enable  <= 1'b1;
         in_valid_ff         <= 1'b0;
         state_ff            <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_payload_ff  <= in_payload_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
